// ===== rtl/core/ckef_pkg.sv =====
// Package for the cluster Kruskal edge filter: payload widths, operation
// codes and the sequencer state type. No dependencies.
package ckef_pkg;

  localparam int VERTEX_W  = 12;
  localparam int CLUSTER_W = 6;
  localparam int COUNT_W   = 7;
  localparam int MODE_W    = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_START  = 2'd0,
    MODE_PRESET = 2'd1,
    MODE_EDGE   = 2'd2,
    MODE_READ   = 2'd3
  } ckef_mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_REP_A,
    ST_REP_B,
    ST_WALK_A,
    ST_WALK_B,
    ST_LINK,
    ST_FIX_B,
    ST_READ,
    ST_DONE
  } ckef_state_t;

endpackage

// ===== rtl/core/ckef_if.sv =====
// Valid/ready channel interfaces for the edge filter's input and result beats.
// Depends on ckef_pkg for the field widths.
interface ckef_in_if import ckef_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [MODE_W-1:0]    mode;
  logic [VERTEX_W-1:0]  vertex_a;
  logic [CLUSTER_W-1:0] cluster_a;
  logic [VERTEX_W-1:0]  vertex_b;
  logic [CLUSTER_W-1:0] cluster_b;

  modport source (output valid, mode, vertex_a, cluster_a, vertex_b, cluster_b,
                  input ready);
  modport sink   (input valid, mode, vertex_a, cluster_a, vertex_b, cluster_b,
                  output ready);
endinterface

interface ckef_out_if import ckef_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                accepted;
  logic                complete;
  logic [COUNT_W-1:0]  components_left;
  logic                rep_valid;
  logic [VERTEX_W-1:0] rep_vertex;

  modport source (output valid, accepted, complete, components_left, rep_valid,
                  rep_vertex, input ready);
  modport sink   (input valid, accepted, complete, components_left, rep_valid,
                  rep_vertex, output ready);
endinterface

// ===== rtl/core/ckef_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ckef_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/cluster_kruskal_edge_filter_top.sv =====
// Top level of the cluster Kruskal edge filter.
// Depends on ckef_pkg, ckef_in_if / ckef_out_if and ckef_ram.

// Kruskal edge filter for a generalized minimum spanning tree over clusters.
// Each input beat carries a mode: start (clear representatives and the
// union-find forest, load the component count from the value written on
// cfg_wdata, clamped to 1..MAX_CLUSTERS), preset a representative, offer
// an edge, or read a representative. Every input beat yields exactly one
// result beat. The block takes one beat at a time: in_ready is high only
// while the sequencer is idle. An accepted edge walks from each endpoint's
// cluster to its root over the parent links; the walk reads the parent RAM
// once per hop through its single read port, and the number of hops is at
// most the active cluster count minus one. An edge is refused when both
// clusters already share a root, on range or completion, or on the
// representative check. Representative vertices live in one RAM, parent
// links in another; parent links and representative-set bits use
// per-entry valid flops, so start clears them with no clearing pass. The
// result waits in an output register, so a stalled sink holds only the
// final hand-off.
module cluster_kruskal_edge_filter_top
  import ckef_pkg::*;
#(
  parameter int MAX_CLUSTERS = 64,
  parameter int MAX_VERTICES = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  ckef_in_if.sink            in_ch,
  ckef_out_if.source         out_ch,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_wdata
);

  localparam int CW   = $clog2(MAX_CLUSTERS);
  localparam int CNTW = $clog2(MAX_CLUSTERS + 1);

  // Clamp the configured count into 1..MAX_CLUSTERS.
  function automatic logic [CNTW-1:0] clamp_count(input logic [COUNT_W-1:0] c);
    logic [CNTW-1:0] r;
    if (c == '0) begin
      r = CNTW'(1);
    end else if (32'(c) > 32'(MAX_CLUSTERS)) begin
      r = CNTW'(MAX_CLUSTERS);
    end else begin
      r = CNTW'(c);
    end
    return r;
  endfunction

  // Sequencer and item registers
  ckef_state_t          state_r, state_nxt;
  ckef_mode_t           mode_r, mode_nxt;
  logic [VERTEX_W-1:0]  va_r, va_nxt, vb_r, vb_nxt;
  logic [CLUSTER_W-1:0] ca_r, ca_nxt, cb_r, cb_nxt;

  // Configuration and run state
  logic [COUNT_W-1:0]      cfg_r, cfg_nxt;
  logic [CNTW-1:0]         active_r, active_nxt;
  logic [CNTW-1:0]         comp_r, comp_nxt;
  logic [MAX_CLUSTERS-1:0] rep_set_r, rep_set_nxt;
  logic [MAX_CLUSTERS-1:0] pvalid_r, pvalid_nxt;

  // Root walk registers
  logic [CW-1:0] x_r, x_nxt;
  logic [CW-1:0] ra_r, ra_nxt;

  // Pending result fields
  logic                acc_r, acc_nxt;
  logic                rv_r, rv_nxt;
  logic [VERTEX_W-1:0] rvx_r, rvx_nxt;

  // Output register
  logic                out_valid_r, out_valid_nxt;
  logic                out_acc_r, out_acc_nxt;
  logic                out_cmp_r, out_cmp_nxt;
  logic [COUNT_W-1:0]  out_comp_r, out_comp_nxt;
  logic                out_rv_r, out_rv_nxt;
  logic [VERTEX_W-1:0] out_rvx_r, out_rvx_nxt;

  // RAM ports
  logic                rep_we;
  logic [CW-1:0]       rep_waddr, rep_raddr;
  logic [VERTEX_W-1:0] rep_wdata, rep_q;
  logic                par_we;
  logic [CW-1:0]       par_waddr, par_wdata, par_q;

  logic [CW-1:0] ca_idx, cb_idx;
  logic          ca_ok, cb_ok, va_ok, vb_ok;
  logic [CW-1:0] walk_p;
  logic          out_free;

  assign ca_idx = CW'(ca_r);
  assign cb_idx = CW'(cb_r);
  assign ca_ok  = 32'(ca_r) < 32'(active_r);
  assign cb_ok  = 32'(cb_r) < 32'(active_r);
  assign va_ok  = 32'(va_r) < 32'(MAX_VERTICES);
  assign vb_ok  = 32'(vb_r) < 32'(MAX_VERTICES);

  // An entry never linked since start is its own parent.
  assign walk_p   = pvalid_r[x_r] ? par_q : x_r;
  assign out_free = !out_valid_r || out_ch.ready;

  ckef_ram #(.WIDTH(VERTEX_W), .DEPTH(MAX_CLUSTERS)) u_rep_ram (
    .clk     (clk),
    .wr_en   (rep_we),
    .wr_addr (rep_waddr),
    .wr_data (rep_wdata),
    .rd_addr (rep_raddr),
    .rd_data (rep_q)
  );

  ckef_ram #(.WIDTH(CW), .DEPTH(MAX_CLUSTERS)) u_par_ram (
    .clk     (clk),
    .wr_en   (par_we),
    .wr_addr (par_waddr),
    .wr_data (par_wdata),
    .rd_addr (x_nxt),
    .rd_data (par_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_r       <= COUNT_W'(64);
      active_r    <= clamp_count(COUNT_W'(64));
      comp_r      <= clamp_count(COUNT_W'(64));
      rep_set_r   <= '0;
      pvalid_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cfg_r       <= cfg_nxt;
      active_r    <= active_nxt;
      comp_r      <= comp_nxt;
      rep_set_r   <= rep_set_nxt;
      pvalid_r    <= pvalid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    va_r       <= va_nxt;
    ca_r       <= ca_nxt;
    vb_r       <= vb_nxt;
    cb_r       <= cb_nxt;
    x_r        <= x_nxt;
    ra_r       <= ra_nxt;
    acc_r      <= acc_nxt;
    rv_r       <= rv_nxt;
    rvx_r      <= rvx_nxt;
    out_acc_r  <= out_acc_nxt;
    out_cmp_r  <= out_cmp_nxt;
    out_comp_r <= out_comp_nxt;
    out_rv_r   <= out_rv_nxt;
    out_rvx_r  <= out_rvx_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    va_nxt        = va_r;
    ca_nxt        = ca_r;
    vb_nxt        = vb_r;
    cb_nxt        = cb_r;
    cfg_nxt       = cfg_we ? cfg_wdata : cfg_r;
    active_nxt    = active_r;
    comp_nxt      = comp_r;
    rep_set_nxt   = rep_set_r;
    pvalid_nxt    = pvalid_r;
    x_nxt         = x_r;
    ra_nxt        = ra_r;
    acc_nxt       = acc_r;
    rv_nxt        = rv_r;
    rvx_nxt       = rvx_r;
    out_acc_nxt   = out_acc_r;
    out_cmp_nxt   = out_cmp_r;
    out_comp_nxt  = out_comp_r;
    out_rv_nxt    = out_rv_r;
    out_rvx_nxt   = out_rvx_r;
    // Drop the result once the sink takes it.
    out_valid_nxt = out_valid_r && !out_ch.ready;
    in_ch.ready   = 1'b0;
    rep_we        = 1'b0;
    rep_waddr     = ca_idx;
    rep_wdata     = va_r;
    rep_raddr     = ca_idx;
    par_we        = 1'b0;
    par_waddr     = ra_r;
    par_wdata     = x_r;

    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          mode_nxt  = ckef_mode_t'(in_ch.mode);
          va_nxt    = in_ch.vertex_a;
          ca_nxt    = in_ch.cluster_a;
          vb_nxt    = in_ch.vertex_b;
          cb_nxt    = in_ch.cluster_b;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        acc_nxt = 1'b0;
        rv_nxt  = 1'b0;
        rvx_nxt = '0;
        case (mode_r)
          MODE_START: begin
            active_nxt  = clamp_count(cfg_r);
            comp_nxt    = clamp_count(cfg_r);
            rep_set_nxt = '0;
            pvalid_nxt  = '0;
            state_nxt   = ST_DONE;
          end
          MODE_PRESET: begin
            if (ca_ok && va_ok) begin
              rep_we              = 1'b1;
              rep_set_nxt[ca_idx] = 1'b1;
            end
            state_nxt = ST_DONE;
          end
          MODE_EDGE: begin
            // Issue the read of cluster A's representative.
            if (comp_r > CNTW'(1) && ca_ok && cb_ok && va_ok && vb_ok) begin
              state_nxt = ST_REP_A;
            end else begin
              state_nxt = ST_DONE;
            end
          end
          MODE_READ: begin
            state_nxt = ST_READ;
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_REP_A: begin
        rep_raddr = cb_idx;
        if (!rep_set_r[ca_idx] || rep_q == va_r) begin
          state_nxt = ST_REP_B;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_REP_B: begin
        if (!rep_set_r[cb_idx] || rep_q == vb_r) begin
          x_nxt     = ca_idx;
          state_nxt = ST_WALK_A;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_WALK_A: begin
        if (walk_p == x_r) begin
          ra_nxt    = x_r;
          x_nxt     = cb_idx;
          state_nxt = ST_WALK_B;
        end else begin
          x_nxt = walk_p;
        end
      end
      ST_WALK_B: begin
        if (walk_p == x_r) begin
          // Hold the root of B in x_r for the link.
          state_nxt = (x_r == ra_r) ? ST_DONE : ST_LINK;
        end else begin
          x_nxt = walk_p;
        end
      end
      ST_LINK: begin
        par_we              = 1'b1;
        pvalid_nxt[ra_r]    = 1'b1;
        rep_we              = 1'b1;
        rep_set_nxt[ca_idx] = 1'b1;
        comp_nxt            = comp_r - CNTW'(1);
        state_nxt           = ST_FIX_B;
      end
      ST_FIX_B: begin
        rep_we              = 1'b1;
        rep_waddr           = cb_idx;
        rep_wdata           = vb_r;
        rep_set_nxt[cb_idx] = 1'b1;
        acc_nxt             = 1'b1;
        state_nxt           = ST_DONE;
      end
      ST_READ: begin
        if (ca_ok && rep_set_r[ca_idx]) begin
          rv_nxt  = 1'b1;
          rvx_nxt = rep_q;
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // Advance the result into the output register when it is free.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_acc_nxt   = acc_r;
          out_cmp_nxt   = comp_r <= CNTW'(1);
          out_comp_nxt  = COUNT_W'(comp_r);
          out_rv_nxt    = rv_r;
          out_rvx_nxt   = rvx_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.accepted        = out_acc_r;
  assign out_ch.complete        = out_cmp_r;
  assign out_ch.components_left = out_comp_r;
  assign out_ch.rep_valid       = out_rv_r;
  assign out_ch.rep_vertex      = out_rvx_r;

endmodule

// ===== rtl/core/ckef_checker.sv =====
// Port-level assertions for the cluster Kruskal edge filter, bound to the top.
// Depends on ckef_pkg and cluster_kruskal_edge_filter_top.
module ckef_checker
  import ckef_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic                accepted,
  input logic                complete,
  input logic [COUNT_W-1:0]  components_left,
  input logic                rep_valid,
  input logic [VERTEX_W-1:0] rep_vertex
);

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // One item at a time: an accepted input beat closes the input side.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while busy");

  // An accepted edge never carries read-mode fields; a result with no valid representative carries a zero vertex.
  a_mode_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (accepted || !rep_valid) |-> !rep_valid && rep_vertex == '0 ||
      !accepted && rep_valid)
    else $error("result fields from different modes mixed");

  // Completion flag tracks the component count.
  a_complete: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> complete == (components_left <= COUNT_W'(1)))
    else $error("complete disagrees with components_left");

endmodule

bind cluster_kruskal_edge_filter_top ckef_checker u_ckef_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .accepted        (out_ch.accepted),
  .complete        (out_ch.complete),
  .components_left (out_ch.components_left),
  .rep_valid       (out_ch.rep_valid),
  .rep_vertex      (out_ch.rep_vertex)
);
